[src/vertex_transform_viewport_macros.svh]
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Concurrent assertion shorthands, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_VIEWPORT_MACROS_SVH
`define VERTEX_TRANSFORM_VIEWPORT_MACROS_SVH

`ifndef SYNTH
`define VTV_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define VTV_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define VTV_ASSERT_IMPL(label, clk, rst_n, a, b)
`define VTV_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[src/vtv_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths, transaction types and shared helpers for the vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none
package vtv_pkg;

	localparam int DW       = 32;
	localparam int FB       = 16;
	localparam int VP_W     = 14;
	localparam int PROD_W   = 2 * DW;
	localparam int SUM_W    = 2 * DW + 3;
	localparam int NUM_W    = DW + 1 + VP_W + FB + 1;
	localparam int DEN_W    = DW + 1;
	localparam int DIV_BPS  = 4;
	localparam int DIV_NSTG = (NUM_W + DIV_BPS - 1) / DIV_BPS;
	localparam int PAD_W    = DIV_NSTG * DIV_BPS;
	localparam int DIV_LAT  = DIV_NSTG + 1;

	typedef logic signed [DW-1:0]     data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [VP_W-1:0]          vp_t;

	localparam data_t DATA_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam data_t MAT_ONE  = (FB >= DW - 1) ? DATA_MAX : data_t'(64'd1 << FB);
	localparam sum_t  RND      = sum_t'(64'd1 << (FB - 1));

	localparam vp_t VP_W_RST = vp_t'(1024);
	localparam vp_t VP_H_RST = vp_t'(768);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_XFORM = 1'b1
	} op_t;

	typedef enum logic {
		REG_VP_WIDTH  = 1'b0,
		REG_VP_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] entry_index;
		data_t      entry_value;
		data_t      vert_x;
		data_t      vert_y;
		data_t      vert_z;
		data_t      vert_w;
	} vtx_t;

	typedef struct packed {
		data_t clip_x;
		data_t clip_y;
		data_t clip_z;
		data_t clip_w;
		data_t window_x;
		data_t window_y;
		logic  w_was_zero;
	} res_t;

	typedef struct packed {
		logic  vld;
		data_t x;
		data_t y;
		data_t z;
		data_t w;
	} clip_t;

	typedef struct packed {
		data_t x;
		data_t y;
		data_t z;
		data_t w;
		logic  wzero;
	} side_t;

	function automatic data_t sat_sum(input sum_t v);
		if (v > sum_t'(DATA_MAX))
			return DATA_MAX;
		else if (v < sum_t'(DATA_MIN))
			return DATA_MIN;
		else
			return data_t'(v);
	endfunction

endpackage
`default_nettype wire

[src/vertex_transform_viewport.sv]
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide and viewport mapping
// Matrix transform, divide by clip w and mapping to window coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   vtx channel: op 0 writes one column-major matrix entry (no result),
//   op 1 transforms a vertex and yields one transaction on the res channel.
//   cfg port: write enable, index and data set viewport width and height;
//   write it only while no vertex is in flight.
//   Pipeline: matrix multiply and sum (s1 to s3), window setup (s4 to
//   s6), divider stages and divider output register. Throughput: one
//   transaction per clock while no stalled result holds the pipeline;
//   4 quotient bits per divider stage, so its depth sets the latency.
//   A matrix write takes effect for the next vertex accepted.
//   Reset: matrix goes to identity, viewport to 1024 x 768, pipeline empty.
//   res_stall freezes the whole pipeline while a result waits; vtx_stall
//   is raised while it is frozen; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_transform_viewport_macros.svh"
module vertex_transform_viewport (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            vtx_valid,
	output logic           vtx_stall,
	input  vtv_pkg::vtx_t  vtx,
	output logic           res_valid,
	input  wire            res_stall,
	output vtv_pkg::res_t  res,
	input  wire            cfg_we,
	input  wire            cfg_index,
	input  wire [13:0]     cfg_wdata
);
	import vtv_pkg::*;

	logic  adv, take;
	clip_t clip;
	vp_t   vp_w_q, vp_h_q;

	side_t            side_s4, side_s5, side_s6;
	logic             vld_s4, vld_s5, vld_s6;
	logic [DW:0]      magx_s4, magy_s4;
	logic [DW-1:0]    aw_s4, aw_s5, aw_s6;
	logic             negx_s4, negy_s4, negx_s5, negy_s5, negx_s6, negy_s6;
	logic [DW+VP_W:0] px_s5, py_s5;
	logic [NUM_W-1:0] numx_s6, numy_s6;
	logic signed [DW:0] sx, sy;
	data_t            qx, qy;
	side_t            side_d [DIV_LAT];
	logic             vld_d [DIV_LAT];

	assign adv       = !res_valid || !res_stall;
	assign vtx_stall = !adv;
	assign take      = vtx_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= VP_W_RST;
			vp_h_q <= VP_H_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_VP_WIDTH:  vp_w_q <= cfg_wdata;
				REG_VP_HEIGHT: vp_h_q <= cfg_wdata;
				default:       vp_w_q <= vp_w_q;
			endcase
		end
	end

	vtv_mat_mul u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.take   (take),
		.vtx    (vtx),
		.clip   (clip)
	);

	assign sx = (DW+1)'(clip.x) + (DW+1)'(clip.w);
	assign sy = (DW+1)'(clip.y) + (DW+1)'(clip.w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++)
				vld_d[i] <= 1'b0;
		end else if (adv) begin
			vld_s4   <= clip.vld;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_d[0] <= vld_s6;
			for (int i = 1; i < DIV_LAT; i++)
				vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= '{x: clip.x, y: clip.y, z: clip.z, w: clip.w,
				wzero: clip.w == '0};
			magx_s4 <= sx[DW] ? (DW+1)'(-sx) : (DW+1)'(sx);
			magy_s4 <= sy[DW] ? (DW+1)'(-sy) : (DW+1)'(sy);
			aw_s4   <= clip.w[DW-1] ? DW'(-clip.w) : DW'(clip.w);
			negx_s4 <= sx[DW] ^ clip.w[DW-1];
			negy_s4 <= sy[DW] ^ clip.w[DW-1];

			side_s5 <= side_s4;
			px_s5   <= (DW+VP_W+1)'(magx_s4) * (DW+VP_W+1)'(vp_w_q);
			py_s5   <= (DW+VP_W+1)'(magy_s4) * (DW+VP_W+1)'(vp_h_q);
			aw_s5   <= aw_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;

			side_s6 <= side_s5;
			numx_s6 <= {1'b0, px_s5, {FB{1'b0}}} + NUM_W'(aw_s5);
			numy_s6 <= {1'b0, py_s5, {FB{1'b0}}} + NUM_W'(aw_s5);
			aw_s6   <= aw_s5;
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;

			side_d[0] <= side_s6;
			for (int i = 1; i < DIV_LAT; i++)
				side_d[i] <= side_d[i-1];
		end
	end

	vtv_div u_div_x (
		.clk (clk),
		.adv (adv),
		.num (numx_s6),
		.den ({aw_s6, 1'b0}),
		.neg (negx_s6),
		.quo (qx)
	);

	vtv_div u_div_y (
		.clk (clk),
		.adv (adv),
		.num (numy_s6),
		.den ({aw_s6, 1'b0}),
		.neg (negy_s6),
		.quo (qy)
	);

	assign res_valid      = vld_d[DIV_LAT-1];
	assign res.clip_x     = side_d[DIV_LAT-1].x;
	assign res.clip_y     = side_d[DIV_LAT-1].y;
	assign res.clip_z     = side_d[DIV_LAT-1].z;
	assign res.clip_w     = side_d[DIV_LAT-1].w;
	assign res.w_was_zero = side_d[DIV_LAT-1].wzero;
	assign res.window_x   = side_d[DIV_LAT-1].wzero ? '0 : qx;
	assign res.window_y   = side_d[DIV_LAT-1].wzero ? '0 : qy;

	`VTV_ASSERT_IMPL(a_wzero_flag, clk, arst_n, res_valid, (res.clip_w == '0) == res.w_was_zero)
	`VTV_ASSERT_IMPL(a_wzero_win, clk, arst_n, res_valid && res.w_was_zero, res.window_x == '0 && res.window_y == '0)
	`VTV_ASSERT_NEXT(a_hold_s4, clk, arst_n, vld_s4 && !adv, vld_s4)

endmodule
`default_nettype wire

[src/vtv_mat_mul.sv]
// ----------------------------------------------------------------------------
// Vertex transform matrix stage
// Holds the 4x4 matrix and produces saturated clip coordinates in 3 stages.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_mat_mul (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            adv,
	input  wire            take,
	input  vtv_pkg::vtx_t  vtx,
	output vtv_pkg::clip_t clip
);
	import vtv_pkg::*;

	data_t matrix_q [16];
	data_t vin [4];
	prod_t prod_s1 [4][4];
	sum_t  sum_s2 [4][2];
	logic  vld_s1, vld_s2;
	data_t clip_s3 [4];
	logic  vld_s3;
	sum_t  tot [4];

	assign vin[0] = vtx.vert_x;
	assign vin[1] = vtx.vert_y;
	assign vin[2] = vtx.vert_z;
	assign vin[3] = vtx.vert_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				matrix_q[i] <= (i % 5 == 0) ? MAT_ONE : '0;
		end else if (take && vtx.op == OP_WRITE) begin
			matrix_q[vtx.entry_index] <= vtx.entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take && vtx.op == OP_XFORM;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++)
			tot[r] = (sum_s2[r][0] + sum_s2[r][1]) >>> FB;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++)
					prod_s1[r][c] <= prod_t'(matrix_q[c*4+r]) * prod_t'(vin[c]);
				sum_s2[r][0] <= sum_t'(prod_s1[r][0]) + sum_t'(prod_s1[r][1]) + RND;
				sum_s2[r][1] <= sum_t'(prod_s1[r][2]) + sum_t'(prod_s1[r][3]);
				clip_s3[r]   <= sat_sum(tot[r]);
			end
		end
	end

	assign clip.vld = vld_s3;
	assign clip.x   = clip_s3[0];
	assign clip.y   = clip_s3[1];
	assign clip.z   = clip_s3[2];
	assign clip.w   = clip_s3[3];

endmodule
`default_nettype wire

[src/vtv_div.sv]
// ----------------------------------------------------------------------------
// Vertex transform divider
// Pipelined restoring divider, DIV_BPS quotient bits per stage, then signed
// saturation to the data width.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_div (
	input  wire                         clk,
	input  wire                         adv,
	input  wire [vtv_pkg::NUM_W-1:0]    num,
	input  wire [vtv_pkg::DEN_W-1:0]    den,
	input  wire                         neg,
	output vtv_pkg::data_t              quo
);
	import vtv_pkg::*;

	logic [DEN_W-1:0] rem_q [DIV_NSTG];
	logic [PAD_W-1:0] num_q [DIV_NSTG];
	logic [PAD_W-1:0] quo_q [DIV_NSTG];
	logic [DEN_W-1:0] den_q [DIV_NSTG];
	logic             neg_q [DIV_NSTG];
	data_t            quo_out_q;
	logic [PAD_W-1:0] qf;

	for (genvar i = 0; i < DIV_NSTG; i++) begin : g_stg
		logic [DEN_W-1:0] r_in, r;
		logic [PAD_W-1:0] n_in, n, q_in, q;
		logic [DEN_W-1:0] d;
		logic             s_in;
		logic [DEN_W:0]   t;

		if (i == 0) begin : g_first
			assign r_in = '0;
			assign n_in = PAD_W'(num);
			assign q_in = '0;
			assign d    = den;
			assign s_in = neg;
		end else begin : g_next
			assign r_in = rem_q[i-1];
			assign n_in = num_q[i-1];
			assign q_in = quo_q[i-1];
			assign d    = den_q[i-1];
			assign s_in = neg_q[i-1];
		end

		always_comb begin
			r = r_in;
			n = n_in;
			q = q_in;
			t = '0;
			for (int k = 0; k < DIV_BPS; k++) begin
				t = {r, n[PAD_W-1]};
				n = {n[PAD_W-2:0], 1'b0};
				if (t >= {1'b0, d}) begin
					t = t - {1'b0, d};
					q = {q[PAD_W-2:0], 1'b1};
				end else begin
					q = {q[PAD_W-2:0], 1'b0};
				end
				r = t[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i] <= r;
				num_q[i] <= n;
				quo_q[i] <= q;
				den_q[i] <= d;
				neg_q[i] <= s_in;
			end
		end
	end

	assign qf = quo_q[DIV_NSTG-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (neg_q[DIV_NSTG-1])
				quo_out_q <= (qf <= PAD_W'(DATA_MAX) + PAD_W'(1)) ?
					data_t'(-qf) : DATA_MIN;
			else
				quo_out_q <= (qf <= PAD_W'(DATA_MAX)) ? data_t'(qf) : DATA_MAX;
		end
	end

	assign quo = quo_out_q;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Vertex transform testbench
// Drives matrix writes and vertices through the transform, predicts the clip
// vector and window coordinates with a wide-integer model of the datapath, and
// compares every result transaction in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vtv_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vtx_valid = 1'b0;
	logic vtx_stall;
	vtx_t vtx = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [13:0] cfg_wdata = '0;

	data_t mat [16];
	vp_t vp_width, vp_height;
	res_t expected_q [$];
	int errors = 0;
	int cycles = 0;
	int in_idle_pct = 37;
	int out_idle_pct = 37;
	int hold_off = 0;

	vertex_transform_viewport uut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic data_t clamp(input logic signed [191:0] v);
		if (v > 192'sd2147483647)
			return DATA_MAX;
		if (v < -192'sd2147483648)
			return DATA_MIN;
		return data_t'(v);
	endfunction

	function automatic data_t window_coord(input data_t c, input data_t w, input vp_t size);
		logic signed [191:0] s, aw, num, q;
		logic neg;
		s = 192'(signed'(c)) + 192'(signed'(w));
		aw = w < 0 ? -192'(signed'(w)) : 192'(signed'(w));
		neg = (s < 0) != (w < 0);
		num = ((s < 0 ? -s : s) * 192'(size)) <<< FB;
		q = (num + aw) / (2 * aw);
		return clamp(neg ? -q : q);
	endfunction

	function automatic res_t transform_vertex(input vtx_t t);
		logic signed [191:0] acc;
		data_t v [4];
		data_t cl [4];
		res_t r;
		v[0] = t.vert_x; v[1] = t.vert_y; v[2] = t.vert_z; v[3] = t.vert_w;
		for (int row = 0; row < 4; row++) begin
			acc = 192'sd1 <<< (FB - 1);
			for (int col = 0; col < 4; col++)
				acc += 192'(signed'(mat[col*4+row])) * 192'(signed'(v[col]));
			cl[row] = clamp(acc >>> FB);
		end
		r.clip_x = cl[0]; r.clip_y = cl[1]; r.clip_z = cl[2]; r.clip_w = cl[3];
		r.w_was_zero = (cl[3] == 0);
		r.window_x = r.w_was_zero ? '0 : window_coord(cl[0], cl[3], vp_width);
		r.window_y = r.w_was_zero ? '0 : window_coord(cl[1], cl[3], vp_height);
		return r;
	endfunction

	task automatic report(input string what, input data_t got, input data_t want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				report("unexpected transaction", 0, 0);
			end else begin
				res_t e;
				e = expected_q.pop_front();
				if (res.clip_x !== e.clip_x) report("clip_x", res.clip_x, e.clip_x);
				if (res.clip_y !== e.clip_y) report("clip_y", res.clip_y, e.clip_y);
				if (res.clip_z !== e.clip_z) report("clip_z", res.clip_z, e.clip_z);
				if (res.clip_w !== e.clip_w) report("clip_w", res.clip_w, e.clip_w);
				if (res.window_x !== e.window_x)
					report("window_x", res.window_x, e.window_x);
				if (res.window_y !== e.window_y)
					report("window_y", res.window_y, e.window_y);
				if (res.w_was_zero !== e.w_was_zero)
					report("w_was_zero", data_t'(res.w_was_zero), data_t'(e.w_was_zero));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	// valid stays high after acceptance; the next send replaces or drops it, drain drops it
	task automatic send(input vtx_t t);
		while ($urandom_range(99) < in_idle_pct) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx <= t;
		@(posedge clk);
		while (vtx_stall)
			@(posedge clk);
		if (t.op == OP_WRITE)
			mat[t.entry_index] = t.entry_value;
		else
			expected_q.push_back(transform_vertex(t));
	endtask

	task automatic drain();
		vtx_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(input reg_idx_t idx, input vp_t val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_VP_WIDTH) vp_width = val; else vp_height = val;
	endtask

	function automatic data_t rand_data(input int mode);
		case (mode)
			0: return data_t'($urandom);
			1: return data_t'($urandom_range(0, 8 << FB)) - data_t'(4 << FB);
			2: return data_t'($urandom_range(0, 1 << FB)) - data_t'(1 << (FB-1));
			default: return data_t'($urandom_range(0, 3) == 0 ? DATA_MIN : DATA_MAX);
		endcase
	endfunction

	function automatic vtx_t mk_write(input int idx, input data_t val);
		vtx_t t;
		logic [191:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		t = rnd[$bits(vtx_t)-1:0];
		t.op = OP_WRITE;
		t.entry_index = 4'(idx);
		t.entry_value = val;
		return t;
	endfunction

	function automatic vtx_t mk_vertex(input data_t x, input data_t y, input data_t z,
			input data_t w);
		vtx_t t;
		logic [191:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		t = rnd[$bits(vtx_t)-1:0];
		t.op = OP_XFORM;
		t.vert_x = x; t.vert_y = y; t.vert_z = z; t.vert_w = w;
		return t;
	endfunction

	task automatic test_directed();
		send(mk_vertex(32'sh10000, -32'sh10000, 32'sh8000, 32'sh10000));
		send(mk_vertex(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MAX));
		send(mk_vertex(DATA_MIN, DATA_MAX, 0, DATA_MIN));
		send(mk_vertex(32'sh20000, 32'sh10000, 0, 0));
		send(mk_vertex(32'sh1, -32'sh1, 32'sh1, -32'sh1));
		send(mk_write(15, DATA_MAX));
		send(mk_vertex(32'sh10000, 0, 0, DATA_MAX));
		send(mk_write(12, DATA_MIN));
		send(mk_vertex(32'sh30000, 32'sh30000, 32'sh30000, 32'sh10000));
		send(mk_write(3, 32'sh8000));
		send(mk_vertex(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
		send(mk_vertex(32'sh8000, 0, 0, 0));
		for (int i = 0; i < 16; i++)
			send(mk_write(i, (i % 5 == 0) ? 32'sh10000 : 0));
	endtask

	task automatic test_viewport_extremes();
		write_cfg(REG_VP_WIDTH, 14'h3FFF);
		write_cfg(REG_VP_HEIGHT, 14'h0);
		send(mk_vertex(32'sh10000, -32'sh8000, 0, 32'sh10000));
		send(mk_vertex(DATA_MAX, DATA_MIN, 0, 32'sh1));
		send(mk_vertex(-32'sh30000, 32'sh30000, 0, -32'sh10000));
		write_cfg(REG_VP_WIDTH, 14'h0);
		write_cfg(REG_VP_HEIGHT, 14'h3FFF);
		send(mk_vertex(32'sh10000, DATA_MAX, 0, 32'sh1));
		send(mk_vertex(-32'sh8000, -32'sh8000, 0, -32'sh1));
	endtask

	task automatic test_random(input int n);
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			if (mode == 0)
				send(mk_write($urandom_range(0, 15), rand_data($urandom_range(0, 3))));
			else if (mode == 1)
				send(mk_vertex(rand_data(1), rand_data(1), rand_data(1), 0));
			else
				send(mk_vertex(rand_data(mode % 4), rand_data(mode % 4),
					rand_data($urandom_range(0, 3)), rand_data(mode % 4)));
		end
	endtask

	task automatic test_backpressure();
		hold_off = 200;
		test_random(80);
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			mat[i] = (i % 5 == 0) ? MAT_ONE : '0;
		vp_width = VP_W_RST;
		vp_height = VP_H_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_viewport_extremes();
		write_cfg(REG_VP_WIDTH, 14'd1920);
		write_cfg(REG_VP_HEIGHT, 14'd1080);
		test_random(600);
		in_idle_pct = 0;
		out_idle_pct = 0;
		test_random(250);
		in_idle_pct = 37;
		out_idle_pct = 37;
		test_backpressure();
		write_cfg(REG_VP_WIDTH, vp_t'($urandom));
		write_cfg(REG_VP_HEIGHT, vp_t'($urandom));
		test_random(570);
		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/vtv_pkg.sv
src/vtv_mat_mul.sv
src/vtv_div.sv
src/vertex_transform_viewport.sv
tb/sv/tb.sv
